[rtl/range_add_range_min_tree_unit_defines.svh]
// Assertion macros for the range add / range minimum tree.
`ifndef RANGE_ADD_RANGE_MIN_TREE_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_MIN_TREE_UNIT_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define RAMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define RAMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ramt_pkg.sv]
`default_nettype none
package ramt_pkg;

  localparam int VAL_W = 48;
  localparam int ADD_W = 32;
  localparam int POS_W = 11;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [POS_W-1:0]        range_start;
    logic [POS_W-1:0]        range_end;
    logic signed [ADD_W-1:0] add_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_minimum;
    logic                    empty_range;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min;
    logic [VAL_W-1:0]        pend;
  } node_word_t;

endpackage
`default_nettype wire

[rtl/range_add_range_min_tree_unit.sv]
// Each visited node is read (S_RD_NODE), updated (S_NODE) and finished (S_FIN); a node whose
// pending add is passed to its children has both children read and written (S_RD_CH, S_CH),
// and each parent that an add climbs to is recomputed (S_RD_L, S_RD_R, S_REC). An empty
// range visits no node and a full range only the root; all accesses use the single memory port.
// One request is processed at a time; a query result is held in an output register until taken.
// After reset (synchronous, active low) the unit clears all 2*LEAVES nodes, taking no request.
`default_nettype none
`include "range_add_range_min_tree_unit_defines.svh"
module range_add_range_min_tree_unit #(
  parameter int LEAVES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ramt_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ramt_pkg::out_item_t       out_data
);

  localparam int LOG2   = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = LOG2 + 1;
  localparam int CW     = (LOG2 + 1 > ramt_pkg::POS_W) ? LOG2 + 1 : ramt_pkg::POS_W;
  localparam int DW     = $clog2(LOG2 + 1) > 0 ? $clog2(LOG2 + 1) : 1;
  localparam int VW     = ramt_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_NODE, S_NODE, S_RD_CH, S_CH,
    S_FIN, S_RD_L, S_RD_R, S_REC, S_HOLD
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NODE_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [NODE_W-1:0]       k_r, k_nxt;
  logic [NODE_W-1:0]       child_r, child_nxt;
  logic                    right_ch_r, right_ch_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;
  logic                    op_r, op_nxt;
  logic [CW-1:0]           a_r, a_nxt;
  logic [CW-1:0]           b_r, b_nxt;
  logic [VW-1:0]           v_r, v_nxt;
  logic [VW-1:0]           s_r, s_nxt;
  logic                    descend_r, descend_nxt;
  logic signed [VW-1:0]    acc_r, acc_nxt;
  logic                    acc_vld_r, acc_vld_nxt;
  logic signed [VW-1:0]    lmin_r, lmin_nxt;
  logic                    empty_r, empty_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ramt_pkg::out_item_t     out_data_r, out_data_nxt;

  ramt_pkg::node_word_t    mem [NODES];
  ramt_pkg::node_word_t    rdata_r;
  ramt_pkg::node_word_t    wdata;
  logic                    mem_re, mem_we;
  logic [NODE_W-1:0]       raddr, waddr;

  logic [CW-1:0]           size, hi, in_a, in_b_raw, in_b;
  logic                    leaf, covered, disjoint, in_empty, desc_now;
  logic [VW-1:0]           s_now;
  logic signed [VW-1:0]    new_min;
  logic [NODE_W-1:0]       left_k, right_k;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    size     = CW'(LEAVES) >> depth_r;
    hi       = lo_r + size;
    leaf     = (depth_r == DW'(LOG2));
    covered  = (a_r <= lo_r) && (hi <= b_r);
    disjoint = (hi <= a_r) || (b_r <= lo_r);
    left_k   = {k_r[NODE_W-2:0], 1'b1};
    right_k  = (k_r << 1) + NODE_W'(2);
    in_a     = CW'(in_data.range_start);
    in_b_raw = CW'(in_data.range_end);
    in_b     = (in_b_raw > CW'(LEAVES)) ? CW'(LEAVES) : in_b_raw;
    in_empty = (in_a >= in_b);
    // A covered add folds its value into the pending add met at the node.
    s_now    = rdata_r.pend + ((covered && op_r == ramt_pkg::OP_ADD) ? v_r : '0);
    new_min  = rdata_r.min + s_now;
    desc_now = !disjoint && !covered;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    child_nxt     = child_r;
    right_ch_nxt  = right_ch_r;
    lo_nxt        = lo_r;
    depth_nxt     = depth_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    v_nxt         = v_r;
    s_nxt         = s_r;
    descend_nxt   = descend_r;
    acc_nxt       = acc_r;
    acc_vld_nxt   = acc_vld_r;
    lmin_nxt      = lmin_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    raddr         = k_r;
    waddr         = k_r;
    wdata         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + NODE_W'(1);
        if (clr_cnt_r == NODE_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.operation;
          a_nxt       = in_a;
          b_nxt       = in_b;
          v_nxt       = VW'(in_data.add_value);
          k_nxt       = '0;
          lo_nxt      = '0;
          depth_nxt   = '0;
          acc_nxt     = '0;
          acc_vld_nxt = 1'b0;
          empty_nxt   = in_empty;
          if (in_empty) begin
            state_nxt = (in_data.operation == ramt_pkg::OP_QUERY) ? S_HOLD : S_IDLE;
          end else begin
            state_nxt = S_RD_NODE;
          end
        end
      end
      S_RD_NODE: begin
        mem_re    = 1'b1;
        raddr     = k_r;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        mem_we      = 1'b1;
        waddr       = k_r;
        wdata.min   = new_min;
        wdata.pend  = '0;
        s_nxt       = s_now;
        descend_nxt = desc_now;
        if (op_r == ramt_pkg::OP_QUERY && covered) begin
          acc_vld_nxt = 1'b1;
          if (!acc_vld_r || new_min < acc_r) begin
            acc_nxt = new_min;
          end
        end
        if (!leaf && s_now != '0) begin
          child_nxt    = left_k;
          right_ch_nxt = 1'b0;
          state_nxt    = S_RD_CH;
        end else if (desc_now) begin
          k_nxt     = left_k;
          depth_nxt = depth_r + DW'(1);
          state_nxt = S_RD_NODE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD_CH: begin
        mem_re    = 1'b1;
        raddr     = child_r;
        state_nxt = S_CH;
      end
      S_CH: begin
        mem_we     = 1'b1;
        waddr      = child_r;
        wdata.min  = rdata_r.min;
        wdata.pend = rdata_r.pend + s_r;
        if (!right_ch_r) begin
          child_nxt    = child_r + NODE_W'(1);
          right_ch_nxt = 1'b1;
          state_nxt    = S_RD_CH;
        end else if (descend_r) begin
          k_nxt     = left_k;
          depth_nxt = depth_r + DW'(1);
          state_nxt = S_RD_NODE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (k_r == '0) begin
          state_nxt = (op_r == ramt_pkg::OP_QUERY) ? S_HOLD : S_IDLE;
        end else if (k_r[0]) begin
          // Left child done: move on to its right sibling.
          k_nxt     = k_r + NODE_W'(1);
          lo_nxt    = lo_r + size;
          state_nxt = S_RD_NODE;
        end else begin
          // Right child done: climb to the parent.
          k_nxt     = (k_r >> 1) - NODE_W'(1);
          depth_nxt = depth_r - DW'(1);
          lo_nxt    = lo_r - size;
          state_nxt = (op_r == ramt_pkg::OP_ADD) ? S_RD_L : S_FIN;
        end
      end
      S_RD_L: begin
        mem_re    = 1'b1;
        raddr     = left_k;
        state_nxt = S_RD_R;
      end
      S_RD_R: begin
        lmin_nxt  = rdata_r.min;
        mem_re    = 1'b1;
        raddr     = right_k;
        state_nxt = S_REC;
      end
      S_REC: begin
        mem_we     = 1'b1;
        waddr      = k_r;
        wdata.min  = (rdata_r.min < lmin_r) ? rdata_r.min : lmin_r;
        wdata.pend = '0;
        state_nxt  = S_FIN;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.range_minimum = acc_r;
          out_data_nxt.empty_range   = empty_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    child_r    <= child_nxt;
    right_ch_r <= right_ch_nxt;
    lo_r       <= lo_nxt;
    depth_r    <= depth_nxt;
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    v_r        <= v_nxt;
    s_r        <= s_nxt;
    descend_r  <= descend_nxt;
    acc_r      <= acc_nxt;
    acc_vld_r  <= acc_vld_nxt;
    lmin_r     <= lmin_nxt;
    empty_r    <= empty_nxt;
    out_data_r <= out_data_nxt;
  end

  // Reads and writes never share a cycle, so a read always sees the last write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  `RAMT_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re, "memory read and write in one cycle")
  `RAMT_ASSERT_NOW(a_node_after_read, state_r == S_NODE,
                   $past(state_r) == S_RD_NODE, "node data used without a read")
  `RAMT_ASSERT_NEXT(a_query_busy,
                    in_valid && in_ready && in_data.operation == ramt_pkg::OP_QUERY,
                    !in_ready, "query request did not block input")

endmodule
`default_nettype wire

[bench/range_add_range_min_tree_unit_test.sv]
module range_add_range_min_tree_unit_test;

  localparam int LEAVES = 1024;
  localparam int STALL_LIMIT = 20000;

  class min_result_board;
    logic [ramt_pkg::VAL_W-1:0] elem [LEAVES];
    ramt_pkg::out_item_t pending_q [$];
    int errors;

    function new();
      foreach (elem[i]) elem[i] = '0;
      errors = 0;
    endfunction

    // Element values are tracked flat; the tree is only an implementation detail.
    function void note_request(ramt_pkg::in_item_t req);
      int lo, hi;
      logic [ramt_pkg::VAL_W-1:0] ext, best;
      ramt_pkg::out_item_t res;
      lo = req.range_start;
      hi = (req.range_end > LEAVES) ? LEAVES : req.range_end;
      ext = {{(ramt_pkg::VAL_W-ramt_pkg::ADD_W){req.add_value[ramt_pkg::ADD_W-1]}},
             req.add_value};
      if (req.operation == ramt_pkg::OP_ADD) begin
        for (int i = lo; i < hi; i++) elem[i] = elem[i] + ext;
      end else begin
        if (lo >= hi) begin
          res.range_minimum = '0;
          res.empty_range = 1'b1;
        end else begin
          best = elem[lo];
          for (int i = lo + 1; i < hi; i++)
            if ($signed(elem[i]) < $signed(best)) best = elem[i];
          res.range_minimum = best;
          res.empty_range = 1'b0;
        end
        pending_q.push_back(res);
      end
    endfunction

    task check_result(ramt_pkg::out_item_t got);
      ramt_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no query outstanding");
        return;
      end
      want = pending_q.pop_front();
      if (got.range_minimum !== want.range_minimum)
        report_mismatch($sformatf("range_minimum got %0d want %0d",
                                  got.range_minimum, want.range_minimum));
      if (got.empty_range !== want.empty_range)
        report_mismatch($sformatf("empty_range got %0b want %0b",
                                  got.empty_range, want.empty_range));
    endtask

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ramt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ramt_pkg::out_item_t out_data;

  min_result_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  range_add_range_min_tree_unit #(.LEAVES(LEAVES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_request(in_data);
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Valid stays high after an accept until the next request or an idle cycle replaces it.
  task automatic send_request(ramt_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_fields(logic op, int lo, int hi, logic [ramt_pkg::ADD_W-1:0] v);
    ramt_pkg::in_item_t req;
    req.operation = op;
    req.range_start = ramt_pkg::POS_W'(lo);
    req.range_end = ramt_pkg::POS_W'(hi);
    req.add_value = v;
    send_request(req);
  endtask

  // Mostly narrow ranges keep sums readable; some cover odd or full spans.
  task automatic send_random(int count);
    int lo, hi, pick;
    logic [ramt_pkg::ADD_W-1:0] v;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        lo = $urandom_range(LEAVES - 1);
        hi = lo + $urandom_range(64);
      end else if (pick < 8) begin
        lo = $urandom_range(LEAVES);
        hi = $urandom_range(LEAVES);
      end else begin
        lo = $urandom_range(2047);
        hi = $urandom_range(2047);
      end
      v = (pick == 9) ? {$urandom_range(1) ? 1'b1 : 1'b0, {(ramt_pkg::ADD_W-1){$urandom_range(1)
            ? 1'b1 : 1'b0}}} : $urandom;
      send_fields($urandom_range(1) ? ramt_pkg::OP_ADD : ramt_pkg::OP_QUERY, lo, hi, v);
    end
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_fields(ramt_pkg::OP_QUERY, 0, LEAVES, 0);
    send_fields(ramt_pkg::OP_ADD, 0, LEAVES, 32'h7fff_ffff);
    send_fields(ramt_pkg::OP_QUERY, 0, 1, 0);
    send_fields(ramt_pkg::OP_ADD, 5, 6, 32'h8000_0000);
    send_fields(ramt_pkg::OP_QUERY, 0, LEAVES, 0);
    send_fields(ramt_pkg::OP_QUERY, 5, 5, 0);
    send_fields(ramt_pkg::OP_QUERY, 9, 3, 0);
    send_fields(ramt_pkg::OP_ADD, 7, 7, 32'h1234_5678);
    send_fields(ramt_pkg::OP_ADD, 900, 2047, 32'hffff_ffff);
    send_fields(ramt_pkg::OP_QUERY, 1000, 2047, 0);
    send_fields(ramt_pkg::OP_QUERY, LEAVES, 2047, 0);
    send_fields(ramt_pkg::OP_QUERY, 2047, 2047, 0);
    send_fields(ramt_pkg::OP_QUERY, LEAVES - 1, LEAVES, 0);
    send_fields(ramt_pkg::OP_ADD, 511, 513, 32'h8000_0000);
    send_fields(ramt_pkg::OP_QUERY, 510, 514, 0);
    // Add the most negative 32-bit value to the full range five times.
    repeat (5) send_fields(ramt_pkg::OP_ADD, 0, LEAVES, 32'h8000_0000);
    send_fields(ramt_pkg::OP_QUERY, 0, LEAVES, 0);
    send_fields(ramt_pkg::OP_QUERY, 512, 513, 0);

    send_idle_pct = 25; recv_idle_pct = 62;
    send_random(300);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_random(20);
        idle_input();
      end
    join
    send_idle_pct = 62; recv_idle_pct = 25;
    send_random(280);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(300);
    idle_input();
    drain();

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
